### hdl/point_cloud_box_radius_search_macros.svh
// Assertion macros for the point cloud box radius search block.
// Used by the controller; the assertions expect clk_i and rst_ni in scope.
`ifndef POINT_CLOUD_BOX_RADIUS_SEARCH_MACROS_SVH
`define POINT_CLOUD_BOX_RADIUS_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define PCBRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// A condition that must be followed by another one in the next cycle.
`define PCBRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define PCBRS_ASSERT(lbl, prop, msg)
`define PCBRS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/pcbrs_pkg.sv
// Package of the point cloud box radius search block: widths, register
// indexes and the command and status bundles between controller and datapath.
// Depends on nothing.
package pcbrs_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COORD_W    = 32;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SUM_W      = COORD_W + ADDR_W;
  localparam int MID_W      = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int RAD_W      = SQ_W + 2;
  localparam int HALF_W     = 33;
  localparam int COV_W      = 17;
  localparam int FRAC_W     = 16;
  localparam int SCALE_W    = 10;
  localparam int SCALE_FRAC = 8;
  localparam int SHIFT_W    = MID_W + SCALE_W - SCALE_FRAC;
  localparam int ITER_W     = 6;
  localparam int CFG_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_NUM_W  = CNT_W + FRAC_W;
  localparam int DIV_W      = (SUM_W > DIV_NUM_W) ? SUM_W : DIV_NUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int SQRT_CNT_W = $clog2(MID_W + 1);

  localparam logic [COV_W-1:0]   FULL_COVER      = COV_W'(1 << FRAC_W);
  localparam logic [COV_W-1:0]   HIGH_FRAC_RST   = COV_W'(62259);
  localparam logic [COV_W-1:0]   STOP_TOL_RST    = COV_W'(66);
  localparam logic [SCALE_W-1:0] SIZE_SCALE_RST  = SCALE_W'(307);
  localparam logic [ITER_W-1:0]  MAX_ITER_RST    = ITER_W'(40);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_FRACTION,
    REG_STOP_TOLERANCE,
    REG_SIZE_SCALE,
    REG_MAX_ITERATIONS
  } cfg_reg_e;

  // What the shared divider is working on.
  typedef enum logic [1:0] {
    DIV_X,
    DIV_Y,
    DIV_Z,
    DIV_COV
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_go;
    div_sel_e div_sel;
    logic     walk_go;
    logic     walk_max;
    logic     sqrt_go;
    logic     set_prev;
    logic     bisect;
    logic     scale;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_done;
    logic sqrt_done;
    logic tol_met;
    logic limit_met;
  } status_t;

endpackage

### hdl/point_cloud_box_radius_search.sv
// Top level of the point cloud box radius search block.
// Depends on pcbrs_pkg, pcbrs_ctrl and pcbrs_dp.
//
//   Channel   Handshake                  Payload
//   points    start / busy               point_x_i, point_y_i, point_z_i, last_point_i
//   result    result_valid_o (strobe)    center_*_o, half_size_o, coverage_o,
//                                        passes_used_o, hit_limit_o
//   config    cfg_we_i                   cfg_index_i, cfg_data_i
//
// Points load one per cycle while busy is low. After the last point the block
// runs three serial divisions, one walk of the N stored points, a square root,
// and then for each bisection pass a walk of the N points, a division and the
// decide and step states; the single memory read port and the shared bit-serial
// divider keep these steps serial. Scaling and the result strobe end the run.
// There is no clearing pass after reset; the result strobe lasts one cycle and
// the receiver cannot stall it.
module point_cloud_box_radius_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [pcbrs_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [pcbrs_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [pcbrs_pkg::COORD_W-1:0] point_z_i,
  input  logic                                 last_point_i,
  output logic                                 result_valid_o,
  output logic signed [pcbrs_pkg::COORD_W-1:0] center_x_o,
  output logic signed [pcbrs_pkg::COORD_W-1:0] center_y_o,
  output logic signed [pcbrs_pkg::COORD_W-1:0] center_z_o,
  output logic [pcbrs_pkg::HALF_W-1:0]         half_size_o,
  output logic [pcbrs_pkg::COV_W-1:0]          coverage_o,
  output logic [pcbrs_pkg::ITER_W-1:0]         passes_used_o,
  output logic                                 hit_limit_o,
  input  logic                                 cfg_we_i,
  input  logic [pcbrs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pcbrs_pkg::CFG_W-1:0]          cfg_data_i
);
  import pcbrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencing.
  pcbrs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .last_point_i (last_point_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .busy_o       (busy),
    .done_o       (result_valid_o),
    .hit_o        (hit_limit_o)
  );

  // Arithmetic and storage.
  pcbrs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .center_x_o    (center_x_o),
    .center_y_o    (center_y_o),
    .center_z_o    (center_z_o),
    .half_size_o   (half_size_o),
    .coverage_o    (coverage_o),
    .passes_used_o (passes_used_o)
  );

endmodule

### hdl/pcbrs_div.sv
// Restoring divider, one quotient bit per cycle, shared by the centroid and
// coverage divisions. Depends on pcbrs_pkg.
module pcbrs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [pcbrs_pkg::DIV_W-1:0] dividend_i,
  input  logic [pcbrs_pkg::CNT_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [pcbrs_pkg::DIV_W-1:0] quotient_o
);
  import pcbrs_pkg::*;

  logic [CNT_W-1:0]     rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [CNT_W:0]       rem_t;
  logic                 ge;

  // One trial subtraction of the divisor per cycle.
  always_comb begin
    rem_t = {rem_q, quo_q[DIV_W-1]};
    ge    = rem_t >= (CNT_W + 1)'(divisor_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        rem_q <= '0;
        quo_q <= dividend_i;
        cnt_q <= DIV_CNT_W'(DIV_W);
      end else if (cnt_q != '0) begin
        rem_q <= ge ? CNT_W'(rem_t - (CNT_W + 1)'(divisor_i)) : CNT_W'(rem_t);
        quo_q <= {quo_q[DIV_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hdl/pcbrs_dp.sv
// Datapath: configuration registers, point memory, sums, the walk pipeline over
// the stored points, integer square root, bisection bounds and final scaling.
// Depends on pcbrs_pkg and pcbrs_div.
module pcbrs_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcbrs_pkg::cmd_t                     cmd_i,
  output pcbrs_pkg::status_t                  status_o,
  input  logic                                cfg_we_i,
  input  logic [pcbrs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pcbrs_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic signed [pcbrs_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [pcbrs_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [pcbrs_pkg::COORD_W-1:0] point_z_i,
  output logic signed [pcbrs_pkg::COORD_W-1:0] center_x_o,
  output logic signed [pcbrs_pkg::COORD_W-1:0] center_y_o,
  output logic signed [pcbrs_pkg::COORD_W-1:0] center_z_o,
  output logic [pcbrs_pkg::HALF_W-1:0]        half_size_o,
  output logic [pcbrs_pkg::COV_W-1:0]         coverage_o,
  output logic [pcbrs_pkg::ITER_W-1:0]        passes_used_o
);
  import pcbrs_pkg::*;

  // Configuration registers.
  logic [COV_W-1:0]   high_frac_q;
  logic [COV_W-1:0]   stop_tol_q;
  logic [SCALE_W-1:0] size_scale_q;
  logic [ITER_W-1:0]  max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_frac_q  <= HIGH_FRAC_RST;
      stop_tol_q   <= STOP_TOL_RST;
      size_scale_q <= SIZE_SCALE_RST;
      max_iter_q   <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_HIGH_FRACTION:  high_frac_q  <= COV_W'(cfg_data_i);
        REG_STOP_TOLERANCE: stop_tol_q   <= COV_W'(cfg_data_i);
        REG_SIZE_SCALE:     size_scale_q <= cfg_data_i[SCALE_W-1:0];
        REG_MAX_ITERATIONS: max_iter_q   <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Point loading: count and running sums.
  logic [CNT_W-1:0]        count_q;
  logic signed [SUM_W-1:0] sum_q [3];
  logic                    store_en;

  assign store_en = cmd_i.load && (count_q < CNT_W'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
      end
    end else if (cmd_i.scale) begin
      count_q <= '0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
      end
    end else if (store_en) begin
      count_q  <= count_q + 1'b1;
      sum_q[0] <= sum_q[0] + SUM_W'(point_x_i);
      sum_q[1] <= sum_q[1] + SUM_W'(point_y_i);
      sum_q[2] <= sum_q[2] + SUM_W'(point_z_i);
    end
  end

  // Walk control over the stored points.
  logic             walk_q;
  logic             max_mode_q;
  logic [CNT_W-1:0] rd_cnt_q;
  logic             s1_v_q, s2_v_q, s3_v_q;
  logic             walk_done_q;
  logic             rd_en;

  assign rd_en = walk_q && (rd_cnt_q < count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q      <= 1'b0;
      max_mode_q  <= 1'b0;
      rd_cnt_q    <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      walk_done_q <= 1'b0;
    end else begin
      walk_done_q <= 1'b0;
      s1_v_q      <= rd_en;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      if (cmd_i.walk_go) begin
        walk_q     <= 1'b1;
        max_mode_q <= cmd_i.walk_max;
        rd_cnt_q   <= '0;
      end else if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end else if (walk_q && !s1_v_q && !s2_v_q && !s3_v_q) begin
        walk_q      <= 1'b0;
        walk_done_q <= 1'b1;
      end
    end
  end

  // Point memory, one write port and one registered read port.
  logic [3*COORD_W-1:0] mem_q [MAX_POINTS];
  logic [3*COORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem_q[count_q[ADDR_W-1:0]] <= {point_x_i, point_y_i, point_z_i};
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_cnt_q[ADDR_W-1:0]];
    end
  end

  // Stage two: distance from the centroid along each axis.
  logic signed [COORD_W-1:0] ctr_q [3];
  logic signed [COORD_W-1:0] pt [3];
  logic signed [COORD_W:0]   diff [3];
  logic [COORD_W-1:0]        mag_d [3];
  logic [COORD_W-1:0]        mag_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pt[k]    = rdata_q[(2-k)*COORD_W +: COORD_W];
      diff[k]  = (COORD_W + 1)'(pt[k]) - (COORD_W + 1)'(ctr_q[k]);
      mag_d[k] = diff[k][COORD_W] ? COORD_W'(-diff[k]) : COORD_W'(diff[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      mag_q <= mag_d;
    end
  end

  // Stage three: squares per axis and the cube test.
  logic [MID_W-1:0] mid_q;
  logic [SQ_W-1:0]  sq_q [3];
  logic             in_q;

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= SQ_W'(mag_q[k]) * SQ_W'(mag_q[k]);
      end
      in_q <= (MID_W'(mag_q[0]) <= mid_q) && (MID_W'(mag_q[1]) <= mid_q) &&
              (MID_W'(mag_q[2]) <= mid_q);
    end
  end

  // Stage four: largest squared distance, or the count of points inside.
  logic [RAD_W-1:0] dist_sq;
  logic [RAD_W-1:0] max_q;
  logic [CNT_W-1:0] inside_q;

  assign dist_sq = RAD_W'(sq_q[0]) + RAD_W'(sq_q[1]) + RAD_W'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= '0;
      inside_q <= '0;
    end else if (cmd_i.walk_go) begin
      max_q    <= '0;
      inside_q <= '0;
    end else if (s3_v_q) begin
      if (max_mode_q) begin
        if (dist_sq > max_q) begin
          max_q <= dist_sq;
        end
      end else if (in_q) begin
        inside_q <= inside_q + 1'b1;
      end
    end
  end

  // Shared divider: centroid means and the coverage fraction.
  logic [DIV_W-1:0]   dividend;
  logic               div_done;
  logic [DIV_W-1:0]   quotient;
  logic               sum_neg;
  logic [SUM_W-1:0]   sum_abs;
  logic [COORD_W-1:0] q_coord;
  logic [COORD_W-1:0] mean_val;
  logic [1:0]         axis;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_X:   axis = 2'd0;
      DIV_Y:   axis = 2'd1;
      DIV_Z:   axis = 2'd2;
      default: axis = 2'd0;
    endcase
    sum_neg = sum_q[axis][SUM_W-1];
    sum_abs = sum_neg ? SUM_W'(-sum_q[axis]) : SUM_W'(sum_q[axis]);
    if (cmd_i.div_sel == DIV_COV) begin
      dividend = DIV_W'({inside_q, FRAC_W'(0)});
    end else begin
      dividend = DIV_W'(sum_abs);
    end
    q_coord  = quotient[COORD_W-1:0];
    mean_val = sum_neg ? -q_coord : q_coord;
  end

  pcbrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (cmd_i.div_go),
    .dividend_i (dividend),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  logic [COV_W-1:0] pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= '0;
      for (int k = 0; k < 3; k++) begin
        ctr_q[k] <= '0;
      end
    end else if (div_done) begin
      case (cmd_i.div_sel)
        DIV_X:   ctr_q[0] <= mean_val;
        DIV_Y:   ctr_q[1] <= mean_val;
        DIV_Z:   ctr_q[2] <= mean_val;
        DIV_COV: pct_q    <= quotient[COV_W-1:0];
        default: ;
      endcase
    end
  end

  // Integer square root, two radicand bits per cycle.
  logic [RAD_W-1:0]      rad_q;
  logic [MID_W-1:0]      root_q;
  logic [MID_W+1:0]      srem_q;
  logic [SQRT_CNT_W-1:0] scnt_q;
  logic                  sqrt_done_q;
  logic [MID_W+3:0]      srem_t;
  logic [MID_W+3:0]      trial;
  logic                  sge;

  always_comb begin
    srem_t = {srem_q, rad_q[RAD_W-1 -: 2]};
    trial  = (MID_W + 4)'({root_q, 2'b01});
    sge    = srem_t >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q       <= '0;
      root_q      <= '0;
      srem_q      <= '0;
      scnt_q      <= '0;
      sqrt_done_q <= 1'b0;
    end else begin
      sqrt_done_q <= 1'b0;
      if (cmd_i.sqrt_go) begin
        rad_q  <= max_q;
        root_q <= '0;
        srem_q <= '0;
        scnt_q <= SQRT_CNT_W'(MID_W);
      end else if (scnt_q != '0) begin
        srem_q <= sge ? (MID_W + 2)'(srem_t - trial) : (MID_W + 2)'(srem_t);
        root_q <= {root_q[MID_W-2:0], sge};
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        scnt_q <= scnt_q - 1'b1;
        if (scnt_q == SQRT_CNT_W'(1)) begin
          sqrt_done_q <= 1'b1;
        end
      end
    end
  end

  // Bisection bounds, pass count and the previous coverage.
  logic [MID_W-1:0]  lower_q, upper_q;
  logic [COV_W-1:0]  prev_q;
  logic [ITER_W-1:0] passes_q;
  logic [MID_W-1:0]  new_lower, new_upper, new_mid;
  logic [COV_W-1:0]  cov_diff;
  logic [ITER_W-1:0] limit;

  always_comb begin
    new_lower = lower_q;
    new_upper = upper_q;
    if (pct_q > high_frac_q) begin
      new_upper = mid_q;
    end else if (pct_q < FULL_COVER) begin
      new_lower = mid_q;
    end
    new_mid  = MID_W'(((MID_W + 1)'(new_lower) + (MID_W + 1)'(new_upper)) >> 1);
    cov_diff = (pct_q > prev_q) ? pct_q - prev_q : prev_q - pct_q;
    limit    = (max_iter_q == '0) ? ITER_W'(1) : max_iter_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q  <= '0;
      upper_q  <= '0;
      mid_q    <= '0;
      prev_q   <= '0;
      passes_q <= '0;
    end else begin
      if (sqrt_done_q) begin
        lower_q  <= '0;
        upper_q  <= root_q;
        mid_q    <= root_q >> 1;
        passes_q <= '0;
      end else if (cmd_i.bisect) begin
        lower_q  <= new_lower;
        upper_q  <= new_upper;
        mid_q    <= new_mid;
        passes_q <= passes_q + 1'b1;
      end
      if (cmd_i.set_prev) begin
        prev_q <= pct_q;
      end
    end
  end

  // Final half-size: mid times the Q2.8 scale, saturated.
  logic [MID_W+SCALE_W-1:0]  scaled;
  logic [SHIFT_W+HALF_W-1:0] scaled_ext;
  logic [HALF_W-1:0]         half_q;

  always_comb begin
    scaled     = (MID_W + SCALE_W)'(mid_q) * (MID_W + SCALE_W)'(size_scale_q);
    scaled_ext = (SHIFT_W + HALF_W)'(scaled[MID_W+SCALE_W-1:SCALE_FRAC]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      half_q <= (|scaled_ext[SHIFT_W+HALF_W-1:HALF_W]) ? '1 : scaled_ext[HALF_W-1:0];
    end
  end

  assign status_o.div_done  = div_done;
  assign status_o.walk_done = walk_done_q;
  assign status_o.sqrt_done = sqrt_done_q;
  assign status_o.tol_met   = cov_diff < stop_tol_q;
  assign status_o.limit_met = passes_q >= limit;

  assign center_x_o    = ctr_q[0];
  assign center_y_o    = ctr_q[1];
  assign center_z_o    = ctr_q[2];
  assign half_size_o   = half_q;
  assign coverage_o    = pct_q;
  assign passes_used_o = passes_q;

endmodule

### hdl/pcbrs_ctrl.sv
// Controller: sequences loading, centroid, radius, bisection passes and the
// result strobe. Depends on pcbrs_pkg and the assertion macro header.
`include "point_cloud_box_radius_search_macros.svh"

module pcbrs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               last_point_i,
  input  pcbrs_pkg::status_t status_i,
  output pcbrs_pkg::cmd_t    cmd_o,
  output logic               busy_o,
  output logic               done_o,
  output logic               hit_o
);
  import pcbrs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_X,
    S_MEAN_Y,
    S_MEAN_Z,
    S_MAX_WALK,
    S_ROOT,
    S_COV_WALK,
    S_COV_DIV,
    S_DECIDE,
    S_STEP,
    S_SCALE
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;
  logic   first_q;
  logic   hit_q;
  logic   done_q;

  // Loading is taken straight from the handshake; the rest is registered.
  always_comb begin
    cmd_o      = cmd_q;
    cmd_o.load = start_i && (state_q == S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      first_q <= 1'b0;
      hit_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      cmd_q.div_go   <= 1'b0;
      cmd_q.walk_go  <= 1'b0;
      cmd_q.sqrt_go  <= 1'b0;
      cmd_q.set_prev <= 1'b0;
      cmd_q.bisect   <= 1'b0;
      cmd_q.scale    <= 1'b0;
      done_q         <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i && last_point_i) begin
            state_q       <= S_MEAN_X;
            cmd_q.div_go  <= 1'b1;
            cmd_q.div_sel <= DIV_X;
          end
        end
        S_MEAN_X: begin
          if (status_i.div_done) begin
            state_q       <= S_MEAN_Y;
            cmd_q.div_go  <= 1'b1;
            cmd_q.div_sel <= DIV_Y;
          end
        end
        S_MEAN_Y: begin
          if (status_i.div_done) begin
            state_q       <= S_MEAN_Z;
            cmd_q.div_go  <= 1'b1;
            cmd_q.div_sel <= DIV_Z;
          end
        end
        S_MEAN_Z: begin
          if (status_i.div_done) begin
            state_q        <= S_MAX_WALK;
            cmd_q.walk_go  <= 1'b1;
            cmd_q.walk_max <= 1'b1;
          end
        end
        S_MAX_WALK: begin
          if (status_i.walk_done) begin
            state_q       <= S_ROOT;
            cmd_q.sqrt_go <= 1'b1;
          end
        end
        S_ROOT: begin
          if (status_i.sqrt_done) begin
            state_q        <= S_COV_WALK;
            cmd_q.walk_go  <= 1'b1;
            cmd_q.walk_max <= 1'b0;
            first_q        <= 1'b1;
          end
        end
        S_COV_WALK: begin
          if (status_i.walk_done) begin
            state_q       <= S_COV_DIV;
            cmd_q.div_go  <= 1'b1;
            cmd_q.div_sel <= DIV_COV;
          end
        end
        S_COV_DIV: begin
          if (status_i.div_done) begin
            state_q <= S_DECIDE;
          end
        end
        // The first coverage only seeds the comparison; later ones may stop.
        S_DECIDE: begin
          if (first_q) begin
            first_q        <= 1'b0;
            cmd_q.set_prev <= 1'b1;
            cmd_q.bisect   <= 1'b1;
            state_q        <= S_STEP;
          end else if (status_i.tol_met) begin
            hit_q       <= 1'b0;
            cmd_q.scale <= 1'b1;
            state_q     <= S_SCALE;
          end else begin
            cmd_q.set_prev <= 1'b1;
            if (status_i.limit_met) begin
              hit_q       <= 1'b1;
              cmd_q.scale <= 1'b1;
              state_q     <= S_SCALE;
            end else begin
              cmd_q.bisect <= 1'b1;
              state_q      <= S_STEP;
            end
          end
        end
        S_STEP: begin
          state_q       <= S_COV_WALK;
          cmd_q.walk_go <= 1'b1;
        end
        S_SCALE: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign hit_o  = hit_q;

  `PCBRS_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe longer than one cycle")
  `PCBRS_ASSERT(a_one_cmd, $onehot0({cmd_q.div_go, cmd_q.walk_go, cmd_q.sqrt_go, cmd_q.bisect, cmd_q.scale}), "two datapath commands issued together")
  `PCBRS_ASSERT_NEXT(a_scale_done, cmd_q.scale, done_q && (state_q == S_IDLE), "scaling not followed by the result")

endmodule
